// ===== hw/rtl/i2c_eeprom_address_sequencer_unit_assert.svh =====
// Assertion macros shared by the address sequencer RTL.
`ifndef I2C_EEPROM_ADDRESS_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_EEPROM_ADDRESS_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CEAS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CEAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/i2ceas_pkg.sv =====
// Types and constants of the I2C EEPROM address sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2ceas_pkg;

	// Sequencer phases.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_SLA   = 3'd2,
		PH_HIGH  = 3'd3,
		PH_LOW   = 3'd4
	} phase_t;

	// Requested bus actions.
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_START = 2'd1,
		ACT_BYTE  = 2'd2,
		ACT_STOP  = 2'd3
	} bus_action_t;

	// Final outcome of an address phase.
	typedef enum logic [1:0] {
		OUT_OK     = 2'd0,
		OUT_NACKED = 2'd1,
		OUT_FAILED = 2'd2
	} outcome_t;

	// Request types.
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_STATUS = 1'b1;

	// Bus controller status codes, low three bits cleared.
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_REP_START = 8'h10;
	localparam logic [7:0] ST_SLA_ACK   = 8'h18;
	localparam logic [7:0] ST_SLA_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST  = 8'h38;
	localparam logic [7:0] STATUS_MASK  = 8'hF8;

	localparam logic [7:0] RETRY_LIMIT_RESET = 8'd200;

	// One input transaction.
	typedef struct packed {
		logic        req_type;
		logic [7:0]  dev_address;
		logic [15:0] mem_address;
		logic        wide_address;
		logic [7:0]  bus_status;
	} item_t;

	// One result transaction.
	typedef struct packed {
		bus_action_t bus_action;
		logic [7:0]  tx_byte;
		logic        done_res;
		outcome_t    outcome;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2ceas_fsm.sv =====
// Sequencer state machine: phase, retry budget and saved addressing.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_eeprom_address_sequencer_unit_assert.svh"

module i2ceas_fsm (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire i2ceas_pkg::item_t   item,
	input  wire logic [7:0]          retry_limit,
	output i2ceas_pkg::result_t      res
);

	i2ceas_pkg::phase_t phase_q, phase_d;
	logic [7:0]  retries_left_q, retries_left_d;
	logic [7:0]  sla_byte_q, sla_byte_d;
	logic [15:0] saved_address_q, saved_address_d;
	logic        saved_wide_q, saved_wide_d;
	logic [7:0]  status;
	logic [7:0]  new_sla;

	assign status  = item.bus_status & i2ceas_pkg::STATUS_MASK;
	assign new_sla = item.wide_address ? item.dev_address
		: (item.dev_address | {4'b0000, item.mem_address[10:8], 1'b0});

	// State registers, advanced once per processed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= i2ceas_pkg::PH_IDLE;
			retries_left_q  <= 8'd0;
			sla_byte_q      <= 8'd0;
			saved_address_q <= 16'd0;
			saved_wide_q    <= 1'b0;
		end else if (fire) begin
			phase_q         <= phase_d;
			retries_left_q  <= retries_left_d;
			sla_byte_q      <= sla_byte_d;
			saved_address_q <= saved_address_d;
			saved_wide_q    <= saved_wide_d;
		end
	end

	// Next-state logic.
	always_comb begin
		phase_d         = phase_q;
		retries_left_d  = retries_left_q;
		sla_byte_d      = sla_byte_q;
		saved_address_d = saved_address_q;
		saved_wide_d    = saved_wide_q;
		if (item.req_type == i2ceas_pkg::REQ_START) begin
			saved_address_d = item.mem_address;
			saved_wide_d    = item.wide_address;
			sla_byte_d      = new_sla;
			retries_left_d  = retry_limit;
			phase_d         = i2ceas_pkg::PH_START;
		end else begin
			unique case (phase_q)
				i2ceas_pkg::PH_START: begin
					if (status == i2ceas_pkg::ST_START || status == i2ceas_pkg::ST_REP_START)
						phase_d = i2ceas_pkg::PH_SLA;
					else if (status == i2ceas_pkg::ST_ARB_LOST)
						phase_d = i2ceas_pkg::PH_START;
					else
						phase_d = i2ceas_pkg::PH_IDLE;
				end
				i2ceas_pkg::PH_SLA: begin
					if (status == i2ceas_pkg::ST_SLA_ACK) begin
						phase_d = saved_wide_q ? i2ceas_pkg::PH_HIGH : i2ceas_pkg::PH_LOW;
					end else if (status == i2ceas_pkg::ST_SLA_NACK) begin
						if (retries_left_q <= 8'd1) begin
							retries_left_d = 8'd0;
							phase_d        = i2ceas_pkg::PH_IDLE;
						end else begin
							retries_left_d = retries_left_q - 8'd1;
							phase_d        = i2ceas_pkg::PH_START;
						end
					end else if (status == i2ceas_pkg::ST_ARB_LOST) begin
						phase_d = i2ceas_pkg::PH_START;
					end else begin
						phase_d = i2ceas_pkg::PH_IDLE;
					end
				end
				i2ceas_pkg::PH_HIGH: begin
					if (status == i2ceas_pkg::ST_DATA_ACK)
						phase_d = i2ceas_pkg::PH_LOW;
					else if (status == i2ceas_pkg::ST_ARB_LOST)
						phase_d = i2ceas_pkg::PH_START;
					else
						phase_d = i2ceas_pkg::PH_IDLE;
				end
				i2ceas_pkg::PH_LOW: begin
					if (status == i2ceas_pkg::ST_ARB_LOST)
						phase_d = i2ceas_pkg::PH_START;
					else
						phase_d = i2ceas_pkg::PH_IDLE;
				end
				default: begin
					phase_d = i2ceas_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Output logic: the bus action and completion report for this transaction.
	always_comb begin
		res.bus_action = i2ceas_pkg::ACT_NONE;
		res.tx_byte    = 8'd0;
		res.done_res   = 1'b0;
		res.outcome    = i2ceas_pkg::OUT_OK;
		if (item.req_type == i2ceas_pkg::REQ_START) begin
			res.bus_action = i2ceas_pkg::ACT_START;
		end else begin
			unique case (phase_q)
				i2ceas_pkg::PH_START: begin
					if (status == i2ceas_pkg::ST_START || status == i2ceas_pkg::ST_REP_START) begin
						res.bus_action = i2ceas_pkg::ACT_BYTE;
						res.tx_byte    = sla_byte_q;
					end else if (status == i2ceas_pkg::ST_ARB_LOST) begin
						res.bus_action = i2ceas_pkg::ACT_START;
					end else begin
						res.done_res = 1'b1;
						res.outcome  = i2ceas_pkg::OUT_FAILED;
					end
				end
				i2ceas_pkg::PH_SLA: begin
					if (status == i2ceas_pkg::ST_SLA_ACK) begin
						res.bus_action = i2ceas_pkg::ACT_BYTE;
						res.tx_byte    = saved_wide_q ? saved_address_q[15:8]
							: saved_address_q[7:0];
					end else if (status == i2ceas_pkg::ST_SLA_NACK) begin
						if (retries_left_q <= 8'd1) begin
							res.done_res = 1'b1;
							res.outcome  = i2ceas_pkg::OUT_FAILED;
						end else begin
							res.bus_action = i2ceas_pkg::ACT_START;
						end
					end else if (status == i2ceas_pkg::ST_ARB_LOST) begin
						res.bus_action = i2ceas_pkg::ACT_START;
					end else begin
						res.bus_action = i2ceas_pkg::ACT_STOP;
						res.done_res   = 1'b1;
						res.outcome    = i2ceas_pkg::OUT_FAILED;
					end
				end
				i2ceas_pkg::PH_HIGH, i2ceas_pkg::PH_LOW: begin
					if (status == i2ceas_pkg::ST_DATA_ACK) begin
						if (phase_q == i2ceas_pkg::PH_LOW) begin
							res.done_res = 1'b1;
						end else begin
							res.bus_action = i2ceas_pkg::ACT_BYTE;
							res.tx_byte    = saved_address_q[7:0];
						end
					end else if (status == i2ceas_pkg::ST_DATA_NACK) begin
						res.bus_action = i2ceas_pkg::ACT_STOP;
						res.done_res   = 1'b1;
						res.outcome    = i2ceas_pkg::OUT_NACKED;
					end else if (status == i2ceas_pkg::ST_ARB_LOST) begin
						res.bus_action = i2ceas_pkg::ACT_START;
					end else begin
						res.bus_action = i2ceas_pkg::ACT_STOP;
						res.done_res   = 1'b1;
						res.outcome    = i2ceas_pkg::OUT_FAILED;
					end
				end
				default: begin
					res.bus_action = i2ceas_pkg::ACT_NONE;
				end
			endcase
		end
	end

	// A finished address phase always leaves the sequencer idle.
	`I2CEAS_ASSERT_NEXT(a_done_goes_idle, clk, arst_n, fire && res.done_res,
		phase_q == i2ceas_pkg::PH_IDLE, "finished phase did not return to idle")

	// The retry budget only grows when a new start request reloads it.
	`I2CEAS_ASSERT_NEXT(a_budget_no_growth, clk, arst_n,
		fire && item.req_type == i2ceas_pkg::REQ_STATUS,
		retries_left_q <= $past(retries_left_q), "retry budget grew on a status report")

	// A start request always begins a new phase at the start condition.
	`I2CEAS_ASSERT_NEXT(a_start_restarts, clk, arst_n,
		fire && item.req_type == i2ceas_pkg::REQ_START,
		phase_q == i2ceas_pkg::PH_START, "start request did not restart the phase")

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_eeprom_address_sequencer_unit.sv =====
// Top level of the I2C EEPROM address sequencer: register stages and configuration.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_eeprom_address_sequencer_unit_assert.svh"

// The sequencer takes one transaction per clock cycle in steady state and
// returns exactly one result for each, in order. A transaction is held in an
// input register until its result can move on; the state machine then decides
// the next bus action in a single pass and updates its state as the result is
// written into an output register, where it is offered until it is taken.
// Both register stages advance whenever the output register is empty or being
// taken, so the rate is limited only by the consumer. The retry limit is
// written through its own channel, which is always ready, and takes effect
// at the next start request.
module i2c_eeprom_address_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input transactions
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [7:0]  dev_address,
	input  wire logic [15:0] mem_address,
	input  wire logic        wide_address,
	input  wire logic [7:0]  bus_status,
	// Result transactions
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       bus_action,
	output logic [7:0]       tx_byte,
	output logic             done_res,
	output logic [1:0]       outcome,
	// Configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  retry_limit
);

	logic                valid_s1;
	i2ceas_pkg::item_t   item_s1;
	logic                advance;
	i2ceas_pkg::result_t res;
	i2ceas_pkg::result_t res_s2;
	logic [7:0]          retry_limit_q;

	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= i2ceas_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_valid) begin
			retry_limit_q <= retry_limit;
		end
	end

	// Valid flags of both register stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!out_valid || out_ready)
				out_valid <= valid_s1;
		end
	end

	// Payload of both register stages.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type     <= req_type;
			item_s1.dev_address  <= dev_address;
			item_s1.mem_address  <= mem_address;
			item_s1.wide_address <= wide_address;
			item_s1.bus_status   <= bus_status;
		end
		if (advance)
			res_s2 <= res;
	end

	i2ceas_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.item        (item_s1),
		.retry_limit (retry_limit_q),
		.res         (res)
	);

	assign bus_action = res_s2.bus_action;
	assign tx_byte    = res_s2.tx_byte;
	assign done_res   = res_s2.done_res;
	assign outcome    = res_s2.outcome;

	// A held input transaction is never dropped while the result stage is blocked.
	`I2CEAS_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1,
		"input stage lost a transaction")

	// A byte is only sent while the address phase is still running.
	`I2CEAS_ASSERT_SAME(a_done_no_byte, clk, arst_n, out_valid && done_res,
		bus_action != i2ceas_pkg::ACT_BYTE, "byte requested on a finished phase")

	// A non-success outcome is reported only on completion.
	`I2CEAS_ASSERT_SAME(a_outcome_when_done, clk, arst_n,
		out_valid && outcome != i2ceas_pkg::OUT_OK, done_res,
		"outcome reported before completion")

endmodule

`default_nettype wire
